FILE: src/pds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg: shared types and constants of the pwm duty sequence player
// Operation codes, the classified command passed from front to back, the
// packed result and the constants of the duty to compare conversion.
// ----------------------------------------------------------------------------
package pds_pkg;

  // default configuration of the top level
  localparam int NumChannels = 3;
  localparam int SeqDepth    = 16;

  // channel outputs carried in every result item
  localparam int NumOutCh = 3;

  // reset value of the period register
  localparam logic [15:0] PeriodReset = 16'd999;

  // register map
  localparam logic [1:0] RegPeriodAddr = 2'd0;

  // saturation limit of a duty percentage
  localparam logic [7:0] DutyMax = 8'd100;

  // reciprocal of 100 for the compare division: floor(2^30 / 100)
  localparam int          RecipShift = 30;
  localparam logic [23:0] RecipMul   = 24'd10737418;
  localparam logic [23:0] Hundred    = 24'd100;

  // operation codes of the input item
  localparam logic [2:0] OpUpdate   = 3'd0;
  localparam logic [2:0] OpWrite    = 3'd1;
  localparam logic [2:0] OpStart    = 3'd2;
  localparam logic [2:0] OpSetDuty  = 3'd3;
  localparam logic [2:0] OpOutOn    = 3'd4;
  localparam logic [2:0] OpOutOff   = 3'd5;

  // classified command kinds
  typedef enum logic [2:0] {
    KindNop    = 3'd0,
    KindUpdate = 3'd1,
    KindWrite  = 3'd2,
    KindStart  = 3'd3,
    KindSet    = 3'd4,
    KindOn     = 3'd5,
    KindOff    = 3'd6
  } cmd_kind_e;

  // command held in the queue between front and back
  typedef struct packed {
    cmd_kind_e   kind;
    logic [1:0]  ch;
    logic        ch_ok;
    logic [3:0]  idx;
    logic [6:0]  duty;
    logic [3:0]  size;
  } cmd_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [3:0]                 remaining;
    logic                       irq_en;
    logic [NumOutCh-1:0]        enable;
    logic [NumOutCh-1:0][15:0]  compare;
  } res_t;

endpackage

FILE: src/pwm_duty_sequence_player.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_duty_sequence_player: pwm compare engine with duty sequences
// Top level with the period register, item intake, queue and executor.
// ----------------------------------------------------------------------------
// Each input item gives exactly one result item holding all channel compare
// values, output enables, the update interrupt enable and the entries left on
// the item's channel. Items are handled one at a time by the executor behind
// a two-entry queue, so intake carries on while a result waits to be taken.
// Write entry, start, output on/off and ignored items go straight from idle
// to done; set duty waits for the three-stage compare pipeline. An update
// event scans the channels one after the other, and each active channel goes
// through the store read port and the compare pipeline.
// The period register is to be written only while the block is idle.
// ----------------------------------------------------------------------------
module pwm_duty_sequence_player #(
  parameter int NUM_CHANNELS = pds_pkg::NumChannels,
  parameter int SEQ_DEPTH    = pds_pkg::SeqDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index [3:0], duty_percent [11:4], seq_size [15:12]
  input  logic [15:0] s_axis_tdata,
  // operation [2:0], channel [4:3]
  input  logic [4:0]  s_axis_tuser,
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // compare_ch0 [15:0], compare_ch1 [31:16], compare_ch2 [47:32],
  // enable_ch0 [48], enable_ch1 [49], enable_ch2 [50],
  // update_irq_enabled [51], remaining [55:52]
  output logic [55:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]   period_q;
  logic          push;
  logic          full;
  logic          pop;
  logic          cmd_valid;
  pds_pkg::cmd_t cmd_in;
  pds_pkg::cmd_t cmd_head;
  pds_pkg::res_t res;

  // period register
  assign pready = 1'b1;
  assign prdata = (paddr == pds_pkg::RegPeriodAddr) ? {16'd0, period_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= pds_pkg::PeriodReset;
    end else if (psel && penable && pwrite && pready
                 && (paddr == pds_pkg::RegPeriodAddr)) begin
      period_q <= pwdata[15:0];
    end
  end

  // intake and classification
  pds_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SEQ_DEPTH    (SEQ_DEPTH)
  ) u_front (
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .operation_i    (s_axis_tuser[2:0]),
    .channel_i      (s_axis_tuser[4:3]),
    .entry_index_i  (s_axis_tdata[3:0]),
    .duty_percent_i (s_axis_tdata[11:4]),
    .seq_size_i     (s_axis_tdata[15:12]),
    .full_i         (full),
    .push_o         (push),
    .cmd_o          (cmd_in)
  );

  // command queue
  pds_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_head),
    .valid_o (cmd_valid)
  );

  // execution
  pds_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SEQ_DEPTH    (SEQ_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (period_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = res;

endmodule

FILE: src/pds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_front: input item classification
// Takes input items, saturates the duty, clamps the size, checks channel and
// entry range and pushes one command per item into the queue.
// ----------------------------------------------------------------------------
module pds_front #(
  parameter int NUM_CHANNELS = pds_pkg::NumChannels,
  parameter int SEQ_DEPTH    = pds_pkg::SeqDepth
) (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      operation_i,
  input  logic [1:0]      channel_i,
  input  logic [3:0]      entry_index_i,
  input  logic [7:0]      duty_percent_i,
  input  logic [3:0]      seq_size_i,
  input  logic            full_i,
  output logic            push_o,
  output pds_pkg::cmd_t   cmd_o
);

  logic       ch_ok;
  logic       idx_ok;
  logic [6:0] duty_sat;
  logic [3:0] size_clamp;

  // range checks and saturation
  assign ch_ok      = 32'(channel_i) < NUM_CHANNELS;
  assign idx_ok     = 32'(entry_index_i) < SEQ_DEPTH;
  assign duty_sat   = (duty_percent_i > pds_pkg::DutyMax) ? pds_pkg::DutyMax[6:0]
                                                          : duty_percent_i[6:0];
  assign size_clamp = (32'(seq_size_i) > SEQ_DEPTH) ? 4'(SEQ_DEPTH) : seq_size_i;

  // handshake towards the queue
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // classify the item
  always_comb begin
    cmd_o.ch    = channel_i;
    cmd_o.ch_ok = ch_ok;
    cmd_o.idx   = entry_index_i;
    cmd_o.duty  = duty_sat;
    cmd_o.size  = size_clamp;
    cmd_o.kind  = pds_pkg::KindNop;
    case (operation_i)
      pds_pkg::OpUpdate:  cmd_o.kind = pds_pkg::KindUpdate;
      pds_pkg::OpWrite:   if (ch_ok && idx_ok) cmd_o.kind = pds_pkg::KindWrite;
      pds_pkg::OpStart:   if (ch_ok) cmd_o.kind = pds_pkg::KindStart;
      pds_pkg::OpSetDuty: if (ch_ok) cmd_o.kind = pds_pkg::KindSet;
      pds_pkg::OpOutOn:   if (ch_ok) cmd_o.kind = pds_pkg::KindOn;
      pds_pkg::OpOutOff:  if (ch_ok) cmd_o.kind = pds_pkg::KindOff;
      default:            cmd_o.kind = pds_pkg::KindNop;
    endcase
  end

endmodule

FILE: src/pds_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_queue: two-entry command queue
// Decouples item intake from command execution.
// ----------------------------------------------------------------------------
module pds_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pds_pkg::cmd_t   data_i,
  output logic            full_o,
  input  logic            pop_i,
  output pds_pkg::cmd_t   data_o,
  output logic            valid_o
);

  logic [1:0]    cnt_q, cnt_d;
  logic          wp_q, rp_q;
  pds_pkg::cmd_t slot_q [2];

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = slot_q[rp_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 2'd1;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= data_i;
  end

endmodule

FILE: src/pds_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_cmp: duty to compare value unit
// Three-stage pipeline computing (period+1)*duty/100, saturated to 16 bits,
// with the division done as a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module pds_cmp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [6:0]  duty_i,
  input  logic [15:0] period_i,
  output logic        valid_o,
  output logic [15:0] value_o
);

  logic        v1_q, v2_q, v3_q;
  logic [23:0] x1_q, x2_q;
  logic [47:0] y_q;
  logic [15:0] res_q;
  logic [17:0] q0;
  logic [23:0] q0x100;
  logic [23:0] rem;
  logic [17:0] quo;

  // correction of the reciprocal estimate
  assign q0     = y_q[pds_pkg::RecipShift +: 18];
  assign q0x100 = 24'({6'd0, q0} * pds_pkg::Hundred);
  assign rem    = x2_q - q0x100;
  assign quo    = q0 + {17'd0, rem >= pds_pkg::Hundred};

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    x1_q  <= 24'(({1'b0, period_i} + 17'd1) * {10'd0, duty_i});
    y_q   <= {24'd0, x1_q} * {24'd0, pds_pkg::RecipMul};
    x2_q  <= x1_q;
    res_q <= (quo > 18'h0FFFF) ? 16'hFFFF : quo[15:0];
  end

  assign valid_o = v3_q;
  assign value_o = res_q;

endmodule

FILE: src/pds_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_back: command execution
// Sequencer over the channels, the sequence store, per-channel state and the
// registered result item.
// ----------------------------------------------------------------------------
module pds_back #(
  parameter int NUM_CHANNELS = pds_pkg::NumChannels,
  parameter int SEQ_DEPTH    = pds_pkg::SeqDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     period_i,
  input  logic            cmd_valid_i,
  input  pds_pkg::cmd_t   cmd_i,
  output logic            pop_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output pds_pkg::res_t   res_o
);

  localparam int ChW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CntW       = ChW + 1;
  localparam int IdxW       = $clog2(SEQ_DEPTH);
  localparam int StoreDepth = NUM_CHANNELS * SEQ_DEPTH;
  localparam int AddrW      = $clog2(StoreDepth);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StRead = 5'b00100,
    StCalc = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e          st_q, st_d;
  logic [CntW-1:0] scan_q;
  logic            any_q;
  logic [3:0]      play_q [NUM_CHANNELS];
  logic [3:0]      size_q [NUM_CHANNELS];
  logic [15:0]     cmpv_q [NUM_CHANNELS];
  logic            en_q   [NUM_CHANNELS];
  logic [15:0]     last_q;
  logic            irq_q;
  logic            out_valid_q;
  pds_pkg::res_t   out_q;

  logic [6:0]      mem [StoreDepth];
  logic [6:0]      rd_q;

  logic [ChW-1:0]  ch_ix;
  logic [ChW-1:0]  scan_ix;
  logic [ChW-1:0]  tgt_ix;
  logic            scan_end;
  logic            out_free;
  logic            mem_we, mem_re;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic            cmp_start;
  logic [6:0]      cmp_duty;
  logic            cmp_valid;
  logic [15:0]     cmp_value;
  logic            is_update;
  logic [3:0]      play_nxt;
  pds_pkg::res_t   res_now;

  assign ch_ix     = ChW'(cmd_i.ch);
  assign scan_ix   = scan_q[ChW-1:0];
  assign scan_end  = scan_q == CntW'(NUM_CHANNELS);
  assign is_update = cmd_i.kind == pds_pkg::KindUpdate;
  assign tgt_ix    = is_update ? scan_ix : ch_ix;
  assign out_free  = !out_valid_q || res_ready_i;
  assign play_nxt  = play_q[scan_ix] + 4'd1;

  // store addressing
  assign wr_addr = AddrW'(AddrW'(ch_ix) * AddrW'(SEQ_DEPTH)) + AddrW'(IdxW'(cmd_i.idx));
  assign rd_addr = AddrW'(AddrW'(scan_ix) * AddrW'(SEQ_DEPTH))
                 + AddrW'(IdxW'(play_q[scan_ix]));
  assign mem_we  = (st_q == StIdle) && cmd_valid_i && (cmd_i.kind == pds_pkg::KindWrite);
  assign mem_re  = (st_q == StScan) && !scan_end && (size_q[scan_ix] != 4'd0);

  // compare unit launch
  assign cmp_start = ((st_q == StIdle) && cmd_valid_i && (cmd_i.kind == pds_pkg::KindSet))
                   || (st_q == StRead);
  assign cmp_duty  = (st_q == StRead) ? rd_q : cmd_i.duty;

  pds_cmp u_cmp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmp_start),
    .duty_i   (cmp_duty),
    .period_i (period_i),
    .valid_o  (cmp_valid),
    .value_o  (cmp_value)
  );

  // sequence store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= cmd_i.duty;
    if (mem_re) rd_q <= mem[rd_addr];
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            pds_pkg::KindUpdate: st_d = StScan;
            pds_pkg::KindSet:    st_d = StCalc;
            default:             st_d = StDone;
          endcase
        end
      end
      StScan: begin
        if (scan_end) st_d = StDone;
        else if (size_q[scan_ix] != 4'd0) st_d = StRead;
      end
      StRead: st_d = StCalc;
      StCalc: begin
        if (cmp_valid) st_d = is_update ? StScan : StDone;
      end
      StDone: begin
        if (out_free) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  assign pop_o = (st_q == StDone) && out_free;

  // result as seen after the command
  always_comb begin
    res_now = '0;
    for (int i = 0; i < pds_pkg::NumOutCh; i++) begin
      if (i < NUM_CHANNELS) begin
        res_now.compare[i] = cmpv_q[i];
        res_now.enable[i]  = en_q[i];
      end
    end
    res_now.irq_en    = irq_q;
    res_now.remaining = cmd_i.ch_ok ? 4'(size_q[ch_ix] - play_q[ch_ix]) : 4'd0;
  end

  // control and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      scan_q      <= '0;
      any_q       <= 1'b0;
      last_q      <= 16'd0;
      irq_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        play_q[i] <= 4'd0;
        size_q[i] <= 4'd0;
        cmpv_q[i] <= 16'd0;
        en_q[i]   <= 1'b0;
      end
    end else begin
      st_q <= st_d;
      if (out_valid_q && res_ready_i && !pop_o) out_valid_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (cmd_valid_i) begin
            case (cmd_i.kind)
              pds_pkg::KindUpdate: begin
                scan_q <= '0;
                any_q  <= 1'b0;
              end
              pds_pkg::KindStart: begin
                size_q[ch_ix] <= cmd_i.size;
                play_q[ch_ix] <= 4'd0;
                cmpv_q[ch_ix] <= last_q;
                en_q[ch_ix]   <= 1'b1;
                irq_q         <= 1'b1;
              end
              pds_pkg::KindOn: begin
                cmpv_q[ch_ix] <= last_q;
                en_q[ch_ix]   <= 1'b1;
              end
              pds_pkg::KindOff: begin
                cmpv_q[ch_ix] <= last_q;
                en_q[ch_ix]   <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        StScan: begin
          if (scan_end) begin
            if (!any_q) irq_q <= 1'b0;
          end else if (size_q[scan_ix] == 4'd0) begin
            scan_q <= scan_q + CntW'(1);
          end
        end
        StCalc: begin
          if (cmp_valid) begin
            last_q         <= cmp_value;
            cmpv_q[tgt_ix] <= cmp_value;
            en_q[tgt_ix]   <= 1'b1;
            if (is_update) begin
              // advance the sequence, retire it after its last entry
              if (play_nxt >= size_q[scan_ix]) begin
                play_q[scan_ix] <= 4'd0;
                size_q[scan_ix] <= 4'd0;
              end else begin
                play_q[scan_ix] <= play_nxt;
              end
              any_q  <= 1'b1;
              scan_q <= scan_q + CntW'(1);
            end
          end
        end
        StDone: begin
          if (out_free) out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= res_now;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

FILE: bench/pwm_duty_sequence_player_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_duty_sequence_player_tb: self-checking bench of the duty sequence player
// Random and directed command items go in through the input stream, and the
// period register is reprogrammed over the apb port between phases while the
// block is idle. A cycle-free model of the channels, the sequence store and
// the shared compare predicts every result item, and each one is checked
// field by field. Both stream sides idle and stall at random, and one phase
// starts with a long receiver hold-off so that the block backs up.
// ----------------------------------------------------------------------------
module pwm_duty_sequence_player_tb;

  localparam int NumCh    = pds_pkg::NumChannels;
  localparam int SeqD     = pds_pkg::SeqDepth;
  localparam int PhaseLen = 165;
  localparam int LongHold = 300;
  localparam int Drain    = 40;

  // codes that the block must ignore
  localparam logic [2:0] OpSpareLo  = 3'd6;
  localparam logic [2:0] OpSpareHi  = 3'd7;
  localparam logic [1:0] ChanUnused = 2'd3;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] ch;
    logic [3:0] idx;
    logic [7:0] duty;
    logic [3:0] size;
  } pwm_cmd_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // entry_index [3:0], duty_percent [11:4], seq_size [15:12]
  logic [15:0] s_axis_tdata  = '0;
  // operation [2:0], channel [4:3]
  logic [4:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // compare_ch0..2 [47:0], enable_ch0..2 [50:48], update_irq_enabled [51],
  // remaining [55:52]
  logic [55:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [1:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  pwm_duty_sequence_player u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // shadow state of the player
  logic [6:0]  seq_mem  [NumCh][SeqD];
  logic [3:0]  play_pos [NumCh];
  logic [3:0]  run_len  [NumCh];
  logic [15:0] cmp_val  [NumCh];
  logic        out_en   [NumCh];
  logic [15:0] shared_cmp;
  logic        irq_en;
  logic [15:0] period_reg;

  // stimulus bookkeeping
  pwm_cmd_t        cmd_backlog[$];
  pds_pkg::res_t   pending_results[$];
  pwm_cmd_t        drv_cmd;
  logic [SeqD-1:0] entry_written [NumCh];
  int              phase_items;
  int              err_count;
  int              send_gap;
  int              stall_left;
  int              hold_left;
  bit              hold_req;
  bit              item_taken;
  bit              send_calm;
  bit              take_calm;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one line per mismatch
  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("%0t ns mismatch %s: expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
    err_count++;
  endtask

  // duty percent to compare value at the current period
  function automatic logic [15:0] duty_compare(input logic [7:0] duty);
    logic [31:0] prod;
    logic [7:0]  d;
    d    = (duty > pds_pkg::DutyMax) ? pds_pkg::DutyMax : duty;
    prod = (({16'd0, period_reg} + 32'd1) * {24'd0, d}) / {24'd0, pds_pkg::DutyMax};
    return (prod > 32'h0000_FFFF) ? 16'hFFFF : prod[15:0];
  endfunction

  // apply one command to the shadow state and return the result it gives
  function automatic pds_pkg::res_t play_item(input pwm_cmd_t it);
    pds_pkg::res_t r;
    logic ch_ok;
    logic any_run;
    int   c;
    ch_ok = (it.ch < NumCh);
    if (it.op == pds_pkg::OpUpdate) begin
      any_run = 1'b0;
      for (c = 0; c < NumCh; c++) begin
        if (run_len[c] != 0) begin
          shared_cmp  = duty_compare({1'b0, seq_mem[c][play_pos[c]]});
          cmp_val[c]  = shared_cmp;
          out_en[c]   = 1'b1;
          play_pos[c] = play_pos[c] + 4'd1;
          if (play_pos[c] >= run_len[c]) begin
            run_len[c]  = '0;
            play_pos[c] = '0;
          end
          any_run = 1'b1;
        end
      end
      if (!any_run) irq_en = 1'b0;
    end else if (ch_ok) begin
      case (it.op)
        pds_pkg::OpWrite: begin
          seq_mem[it.ch][it.idx] = (it.duty > pds_pkg::DutyMax) ? pds_pkg::DutyMax[6:0]
                                                                : it.duty[6:0];
        end
        pds_pkg::OpStart: begin
          run_len[it.ch]  = it.size;
          play_pos[it.ch] = '0;
          cmp_val[it.ch]  = shared_cmp;
          out_en[it.ch]   = 1'b1;
          irq_en          = 1'b1;
        end
        pds_pkg::OpSetDuty: begin
          shared_cmp     = duty_compare(it.duty);
          cmp_val[it.ch] = shared_cmp;
          out_en[it.ch]  = 1'b1;
        end
        pds_pkg::OpOutOn: begin
          cmp_val[it.ch] = shared_cmp;
          out_en[it.ch]  = 1'b1;
        end
        pds_pkg::OpOutOff: begin
          cmp_val[it.ch] = shared_cmp;
          out_en[it.ch]  = 1'b0;
        end
        default: ;
      endcase
    end
    r = '0;
    for (c = 0; c < pds_pkg::NumOutCh; c++) begin
      if (c < NumCh) begin
        r.compare[c] = cmp_val[c];
        r.enable[c]  = out_en[c];
      end
    end
    r.irq_en    = irq_en;
    r.remaining = ch_ok ? (run_len[it.ch] - play_pos[it.ch]) : 4'd0;
    return r;
  endfunction

  // field by field comparison of one result item
  task automatic check_result(input pds_pkg::res_t exp_r, input pds_pkg::res_t got_r);
    int c;
    for (c = 0; c < pds_pkg::NumOutCh; c++) begin
      if (got_r.compare[c] !== exp_r.compare[c])
        report_mismatch($sformatf("compare_ch%0d", c), exp_r.compare[c], got_r.compare[c]);
      if (got_r.enable[c] !== exp_r.enable[c])
        report_mismatch($sformatf("enable_ch%0d", c), exp_r.enable[c], got_r.enable[c]);
    end
    if (got_r.irq_en !== exp_r.irq_en)
      report_mismatch("update_irq_enabled", exp_r.irq_en, got_r.irq_en);
    if (got_r.remaining !== exp_r.remaining)
      report_mismatch("remaining", exp_r.remaining, got_r.remaining);
  endtask

  // number of entries written from index zero upwards without a hole
  function automatic int written_prefix(input int c);
    int n;
    n = 0;
    while (n < SeqD && entry_written[c][n]) n++;
    return n;
  endfunction

  // duty values biased towards the saturation edges
  function automatic logic [7:0] rand_duty();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 8'd0;
      1: return pds_pkg::DutyMax;
      2: return 8'd255;
      3: return pds_pkg::DutyMax + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // gap lengths: mostly none or short, now and then long
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic queue_item(input logic [2:0] op, input logic [1:0] ch, input logic [3:0] idx,
                            input logic [7:0] duty, input logic [3:0] size);
    pwm_cmd_t it;
    it = '{op: op, ch: ch, idx: idx, duty: duty, size: size};
    cmd_backlog.push_back(it);
    if (op == pds_pkg::OpWrite && ch < NumCh) entry_written[ch][idx] = 1'b1;
    if (op <= pds_pkg::OpOutOff && (op == pds_pkg::OpUpdate || ch < NumCh)) phase_items++;
  endtask

  // a whole sequence: entries from zero, the start, then some update events
  task automatic queue_sequence();
    logic [1:0] c;
    int n;
    int k;
    c = 2'($urandom_range(0, NumCh - 1));
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 15) : $urandom_range(1, 6);
    for (k = 0; k < n; k++)
      queue_item(pds_pkg::OpWrite, c, 4'(k), rand_duty(), 4'($urandom));
    queue_item(pds_pkg::OpStart, c, 4'($urandom), 8'($urandom), 4'(n));
    for (k = $urandom_range(0, n); k > 0; k--)
      queue_item(pds_pkg::OpUpdate, 2'($urandom), 4'($urandom), 8'($urandom), 4'($urandom));
  endtask

  task automatic queue_random_item();
    int r;
    int p;
    logic [1:0] c;
    logic [3:0] sz;
    r = $urandom_range(0, 99);
    c = 2'($urandom_range(0, NumCh - 1));
    if (r < 30) begin
      queue_item(pds_pkg::OpUpdate, 2'($urandom), 4'($urandom), 8'($urandom), 4'($urandom));
    end else if (r < 42) begin
      queue_item(pds_pkg::OpWrite, c, 4'($urandom), rand_duty(), 4'($urandom));
    end else if (r < 52) begin
      // only sizes whose entries are all written
      p = written_prefix(c);
      if (p > 15) p = 15;
      sz = (p == 0 || $urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, p));
      queue_item(pds_pkg::OpStart, c, 4'($urandom), 8'($urandom), sz);
    end else if (r < 64) begin
      queue_item(pds_pkg::OpSetDuty, c, 4'($urandom), rand_duty(), 4'($urandom));
    end else if (r < 72) begin
      queue_item(pds_pkg::OpOutOn, c, 4'($urandom), 8'($urandom), 4'($urandom));
    end else if (r < 80) begin
      queue_item(pds_pkg::OpOutOff, c, 4'($urandom), 8'($urandom), 4'($urandom));
    end else if (r < 90) begin
      queue_sequence();
    end else if (r < 95) begin
      // unused operation codes
      queue_item(($urandom_range(0, 1) == 0) ? OpSpareLo : OpSpareHi, 2'($urandom),
                 4'($urandom), 8'($urandom), 4'($urandom));
    end else begin
      // channel that does not exist
      queue_item(3'($urandom_range(pds_pkg::OpWrite, pds_pkg::OpOutOff)), ChanUnused,
                 4'($urandom), 8'($urandom), 4'($urandom));
    end
  endtask

  task automatic apb_read(input logic [1:0] addr, output logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b0;
    paddr   = addr;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    data = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // write the period, then read it back
  task automatic program_period(input logic [15:0] val);
    logic [31:0] rd;
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = pds_pkg::RegPeriodAddr;
    pwdata  = {16'($urandom), val};
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    period_reg = val;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    apb_read(pds_pkg::RegPeriodAddr, rd);
    if (rd[15:0] !== val) report_mismatch("period_count readback", val, rd[15:0]);
  endtask

  // wait until every item is taken and every result has come back
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  // input stream driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || item_taken)) begin
      item_taken = 1'b0;
      if ($urandom_range(0, 99) == 0) send_calm = ~send_calm;
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap--;
      end else if (cmd_backlog.size() != 0) begin
        drv_cmd = cmd_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {drv_cmd.size, drv_cmd.duty, drv_cmd.idx};
        s_axis_tuser  <= {drv_cmd.ch, drv_cmd.op};
        send_gap = pick_gap(send_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result stream back-pressure
  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) == 0) take_calm = ~take_calm;
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LongHold;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (take_calm || $urandom_range(0, 99) < 75) begin
      m_axis_tready <= 1'b1;
    end else begin
      stall_left = pick_gap(1'b0);
      m_axis_tready <= 1'b0;
    end
  end

  // prediction on intake, checking on output
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(play_item(drv_cmd));
        item_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0)
          report_mismatch("result with nothing pending", 0, m_axis_tdata);
        else
          check_result(pending_results.pop_front(), pds_pkg::res_t'(m_axis_tdata));
      end
    end
  end

  // run limit
  initial begin
    #6000000;
    $display("*** FAILED ***");
    $finish;
  end

  // main sequence
  initial begin
    logic [31:0] rd;
    logic [15:0] settings [7];
    int ph;
    int c;
    int k;
    for (c = 0; c < NumCh; c++) begin
      entry_written[c] = '0;
      run_len[c]  = '0;
      play_pos[c] = '0;
      cmp_val[c]  = '0;
      out_en[c]   = 1'b0;
      for (k = 0; k < SeqD; k++) seq_mem[c][k] = '0;
    end
    shared_cmp  = '0;
    irq_en      = 1'b0;
    period_reg  = pds_pkg::PeriodReset;
    err_count   = 0;
    phase_items = 0;
    send_gap    = 0;
    stall_left  = 0;
    hold_left   = 0;
    hold_req    = 1'b0;
    item_taken  = 1'b0;
    send_calm   = 1'b0;
    take_calm   = 1'b0;
    settings = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFE, 16'($urandom), 16'($urandom_range(0, 4000)),
                 pds_pkg::PeriodReset};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    apb_read(pds_pkg::RegPeriodAddr, rd);
    if (rd[15:0] !== pds_pkg::PeriodReset)
      report_mismatch("period_count after reset", pds_pkg::PeriodReset, rd[15:0]);

    // directed opening at the reset period
    queue_item(pds_pkg::OpUpdate, 2'd0, 4'd0, 8'd0, 4'd0);       // nothing active, irq low
    queue_item(pds_pkg::OpSetDuty, 2'd0, 4'hF, 8'd0, 4'hF);
    queue_item(pds_pkg::OpSetDuty, 2'd1, 4'd0, 8'd255, 4'd0);    // saturates to full duty
    queue_item(pds_pkg::OpSetDuty, 2'd2, 4'd0, pds_pkg::DutyMax, 4'd0);
    queue_item(pds_pkg::OpOutOff, 2'd0, 4'd0, 8'd0, 4'd0);       // takes the shared compare
    queue_item(pds_pkg::OpOutOn, 2'd1, 4'd0, 8'd0, 4'd0);
    queue_item(pds_pkg::OpSetDuty, ChanUnused, 4'd0, 8'd50, 4'd0);  // missing channel
    queue_item(OpSpareLo, 2'd0, 4'd0, 8'hFF, 4'hF);
    queue_item(OpSpareHi, 2'd2, 4'hF, 8'hAA, 4'd0);
    queue_item(pds_pkg::OpWrite, 2'd0, 4'd0, 8'd30, 4'd0);
    queue_item(pds_pkg::OpWrite, 2'd0, 4'd1, 8'd200, 4'd0);
    queue_item(pds_pkg::OpWrite, 2'd0, 4'hF, 8'd77, 4'd0);
    queue_item(pds_pkg::OpWrite, 2'd1, 4'd0, pds_pkg::DutyMax + 8'd1, 4'd0);
    queue_item(pds_pkg::OpWrite, ChanUnused, 4'd0, 8'd10, 4'd0);
    queue_item(pds_pkg::OpStart, 2'd0, 4'd0, 8'd0, 4'd2);
    queue_item(pds_pkg::OpStart, 2'd1, 4'd0, 8'd0, 4'd1);
    queue_item(pds_pkg::OpStart, 2'd2, 4'd0, 8'd0, 4'd0);        // size zero stops, irq set
    queue_item(pds_pkg::OpUpdate, 2'd0, 4'd0, 8'd0, 4'd0);
    queue_item(pds_pkg::OpUpdate, 2'd1, 4'd0, 8'd0, 4'd0);
    queue_item(pds_pkg::OpUpdate, 2'd2, 4'd0, 8'd0, 4'd0);       // no channel left, irq drops
    queue_item(pds_pkg::OpUpdate, ChanUnused, 4'd0, 8'd0, 4'd0);
    phase_items = 0;
    while (phase_items < PhaseLen) queue_random_item();
    wait_drained();

    // one phase per period setting
    for (ph = 0; ph < 7; ph++) begin
      program_period(settings[ph]);
      if (ph == 3) hold_req = 1'b1;
      phase_items = 0;
      // compare overflow at the top period
      queue_item(pds_pkg::OpSetDuty, 2'd0, 4'd0, pds_pkg::DutyMax, 4'd0);
      queue_item(pds_pkg::OpSetDuty, 2'd1, 4'd0, 8'd255, 4'd0);
      queue_item(pds_pkg::OpOutOn, 2'd2, 4'd0, 8'd0, 4'd0);
      while (phase_items < PhaseLen) queue_random_item();
      wait_drained();
    end

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
